// ===== rtl/bcd_time_of_day_clock_defines.svh =====
// ---------------------------------------------------------------------------
// BCD time-of-day clock: assertion macros
// Shared property forms for the port checker of the time-of-day clock.
// ---------------------------------------------------------------------------
`ifndef BCD_TIME_OF_DAY_CLOCK_DEFINES_SVH
`define BCD_TIME_OF_DAY_CLOCK_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high
`define BTOD_ASSERT_IMP(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("time-of-day clock: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst is high
`define BTOD_ASSERT_NXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("time-of-day clock: next-cycle check failed");

`endif

// ===== rtl/bcdtod_pkg.sv =====
// ---------------------------------------------------------------------------
// BCD time-of-day clock package
// Widths, codes and the BCD step functions of the time-of-day clock.
// ---------------------------------------------------------------------------
`default_nettype none

package bcdtod_pkg;

  localparam int DATA_W  = 32;  // four time bytes
  localparam int CFG_W   = 8;   // widest configuration register
  localparam int CFG_IDX = 3;   // five registers

  localparam logic [7:0] TENTHS_MAX      = 8'd9;
  localparam logic [3:0] UNITS_MAX       = 4'd9;
  localparam logic [3:0] TENS_SIXTY_MAX  = 4'd5;
  localparam logic [3:0] HOUR_UNITS_MAX  = 4'd1;
  localparam logic [2:0] HOUR_TENS_MAX   = 3'd1;

  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_LOAD = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX-1:0] {
    REG_RUN_ENABLE    = 3'd0,
    REG_ALARM_TENTHS  = 3'd1,
    REG_ALARM_SECONDS = 3'd2,
    REG_ALARM_MINUTES = 3'd3,
    REG_ALARM_HOURS   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] value;
    logic       carry;
  } bcd_step_t;

  // Advance a BCD 00-59 byte; carry out on the wrap of the tens digit
  function automatic bcd_step_t step_sixty(input logic [7:0] b);
    logic [3:0] units;
    logic [3:0] tens;
    bcd_step_t  r;
    units   = b[3:0];
    tens    = b[7:4];
    r.carry = 1'b0;
    if (units >= UNITS_MAX) begin
      units = 4'd0;
      if (tens >= TENS_SIXTY_MAX) begin
        tens    = 4'd0;
        r.carry = 1'b1;
      end else begin
        tens = tens + 4'd1;
      end
    end else begin
      units = units + 4'd1;
    end
    r.value = {tens, units};
    return r;
  endfunction

  // Advance the hours byte (00-11, PM in bit 7); flip PM on the wrap
  function automatic logic [7:0] step_hours(input logic [7:0] h);
    logic [3:0] units;
    logic [2:0] tens;
    logic       pm;
    units = h[3:0];
    tens  = h[6:4];
    pm    = h[7];
    if ((tens == 3'd0 && units >= UNITS_MAX) ||
        (tens != 3'd0 && units >= HOUR_UNITS_MAX)) begin
      units = 4'd0;
      if (tens >= HOUR_TENS_MAX) begin
        tens = 3'd0;
        pm   = !pm;
      end else begin
        tens = tens + 3'd1;
      end
    end else begin
      units = units + 4'd1;
    end
    return {pm, tens, units};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bcd_time_of_day_clock.sv =====
// ---------------------------------------------------------------------------
// BCD time-of-day clock with alarm compare
// BCD increment and compare are combinational; results are registered.
// Throughput: one item per clock unless the output stalls.
// Reset clears the time, alarm registers, run enable and the output valid.
// ---------------------------------------------------------------------------
`default_nettype none

module bcd_time_of_day_clock (
  input  logic                            clk,
  input  logic                            rst,
  // Input stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [7:0] load_tenths, [15:8] load_seconds, [23:16] load_minutes,
  // [31:24] load_hours
  input  logic [bcdtod_pkg::DATA_W-1:0]   s_tdata,
  // [0] cmd
  input  logic                            s_tuser,
  // Result stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [7:0] tenths_now, [15:8] seconds_now, [23:16] minutes_now,
  // [31:24] hours_now
  output logic [bcdtod_pkg::DATA_W-1:0]   m_tdata,
  // [0] alarm_hit
  output logic                            m_tuser,
  // Configuration write port
  input  logic                            cfg_wen,
  input  logic [bcdtod_pkg::CFG_IDX-1:0]  cfg_idx,
  input  logic [bcdtod_pkg::CFG_W-1:0]    cfg_wdata
);

  import bcdtod_pkg::*;

  // Configuration registers
  logic       run_enable;
  logic [7:0] alarm_tenths;
  logic [7:0] alarm_seconds;
  logic [7:0] alarm_minutes;
  logic [7:0] alarm_hours;

  // Time of day
  logic [7:0] tenths_count;
  logic [7:0] seconds_bcd;
  logic [7:0] minutes_bcd;
  logic [7:0] hours_bcd;
  logic [7:0] tenths_next;
  logic [7:0] seconds_next;
  logic [7:0] minutes_next;
  logic [7:0] hours_next;
  logic       hit_next;

  // Result register
  logic              out_valid;
  logic [DATA_W-1:0] out_data;
  logic              out_hit;

  logic      in_take;
  bcd_step_t sec_step;
  bcd_step_t min_step;
  logic [7:0] hours_step;

  // Take a new transfer whenever the result register is empty or draining
  assign s_tready = !out_valid || m_tready;
  assign in_take  = s_tvalid && s_tready;

  // Candidate steps of each byte; the carry chain below picks among them
  assign sec_step   = step_sixty(seconds_bcd);
  assign min_step   = step_sixty(minutes_bcd);
  assign hours_step = step_hours(hours_bcd);

  always_comb begin
    tenths_next  = tenths_count;
    seconds_next = seconds_bcd;
    minutes_next = minutes_bcd;
    hours_next   = hours_bcd;
    hit_next     = 1'b0;
    if (s_tuser == CMD_LOAD) begin
      // Preset all four bytes exactly as given, valid BCD or not
      tenths_next  = s_tdata[7:0];
      seconds_next = s_tdata[15:8];
      minutes_next = s_tdata[23:16];
      hours_next   = s_tdata[31:24];
    end else if (run_enable) begin
      // Tenths at nine or above wrap and ripple up through the BCD bytes
      if (tenths_count >= TENTHS_MAX) begin
        tenths_next  = 8'd0;
        seconds_next = sec_step.value;
        if (sec_step.carry) begin
          minutes_next = min_step.value;
          if (min_step.carry) begin
            hours_next = hours_step;
          end
        end
      end else begin
        tenths_next = tenths_count + 8'd1;
      end
      // Compare the advanced time against the alarm
      hit_next = (tenths_next == alarm_tenths) && (seconds_next == alarm_seconds) &&
                 (minutes_next == alarm_minutes) && (hours_next == alarm_hours);
    end
  end

  // Configuration writes; unmapped indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      run_enable    <= 1'b0;
      alarm_tenths  <= 8'd0;
      alarm_seconds <= 8'd0;
      alarm_minutes <= 8'd0;
      alarm_hours   <= 8'd0;
    end else if (cfg_wen) begin
      unique case (cfg_idx)
        REG_RUN_ENABLE:    run_enable    <= cfg_wdata[0];
        REG_ALARM_TENTHS:  alarm_tenths  <= cfg_wdata;
        REG_ALARM_SECONDS: alarm_seconds <= cfg_wdata;
        REG_ALARM_MINUTES: alarm_minutes <= cfg_wdata;
        REG_ALARM_HOURS:   alarm_hours   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Time state advances only on an accepted transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      tenths_count <= 8'd0;
      seconds_bcd  <= 8'd0;
      minutes_bcd  <= 8'd0;
      hours_bcd    <= 8'd0;
    end else if (in_take) begin
      tenths_count <= tenths_next;
      seconds_bcd  <= seconds_next;
      minutes_bcd  <= minutes_next;
      hours_bcd    <= hours_next;
    end
  end

  // Result register: hold while stalled, load with each accepted transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_take) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      out_data <= {hours_next, minutes_next, seconds_next, tenths_next};
      out_hit  <= hit_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tuser  = out_hit;

endmodule

`default_nettype wire

// ===== rtl/bcdtod_checker.sv =====
// ---------------------------------------------------------------------------
// BCD time-of-day clock port checker
// Watches the stream and configuration ports of the time-of-day clock.
// ---------------------------------------------------------------------------
`default_nettype none

`include "bcd_time_of_day_clock_defines.svh"

module bcdtod_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic [bcdtod_pkg::DATA_W-1:0]   s_tdata,
  input logic                            s_tuser,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [bcdtod_pkg::DATA_W-1:0]   m_tdata,
  input logic                            m_tuser,
  input logic                            cfg_wen,
  input logic [bcdtod_pkg::CFG_IDX-1:0]  cfg_idx,
  input logic [bcdtod_pkg::CFG_W-1:0]    cfg_wdata
);

  import bcdtod_pkg::*;

  logic cfg_seen;
  assign cfg_seen = cfg_wen && (cfg_idx == cfg_idx) && (cfg_wdata == cfg_wdata);

  // A stalled result holds its payload while no configuration write is seen
  `BTOD_ASSERT_NXT(a_hold, m_tvalid && !m_tready && !cfg_seen, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

  // No new transfer while a full result register is stalled
  `BTOD_ASSERT_IMP(a_no_take, m_tvalid && !m_tready, !s_tready)

  // A load shows the loaded bytes next cycle and never an alarm
  `BTOD_ASSERT_NXT(a_load, s_tvalid && s_tready && s_tuser == CMD_LOAD, m_tvalid && m_tdata == $past(s_tdata) && !m_tuser)

  // Output is empty in the first cycle after reset
  `BTOD_ASSERT_IMP(a_rst, $past(rst), !m_tvalid)

endmodule

bind bcd_time_of_day_clock bcdtod_checker u_bcdtod_checker (.*);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// Time-of-day clock testbench
// Drives tick and load transfers into the BCD time-of-day clock, keeps its own
// copy of the time and alarm registers, and checks every result transfer field
// by field. Directed wrap cases come first, then random phases with several
// register settings and random idling on both streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import bcdtod_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 100;

  // One expected result transfer
  typedef struct {
    logic [7:0] tenths;
    logic [7:0] seconds;
    logic [7:0] minutes;
    logic [7:0] hours;
    logic       hit;
  } tod_result_t;

  // Tracks the time of day and alarm registers; holds the expected results
  class tod_scoreboard;
    logic        run_en;
    logic [7:0]  alarm_t, alarm_s, alarm_m, alarm_h;
    logic [7:0]  tenths, seconds, minutes, hours;
    tod_result_t expected_times[$];
    int          mismatches;

    function new();
      run_en     = 1'b0;
      alarm_t    = 8'h00;
      alarm_s    = 8'h00;
      alarm_m    = 8'h00;
      alarm_h    = 8'h00;
      tenths     = 8'h00;
      seconds    = 8'h00;
      minutes    = 8'h00;
      hours      = 8'h00;
      mismatches = 0;
    endfunction

    function void store_reg(cfg_reg_t idx, logic [7:0] value);
      case (idx)
        REG_RUN_ENABLE:    run_en  = value[0];
        REG_ALARM_TENTHS:  alarm_t = value;
        REG_ALARM_SECONDS: alarm_s = value;
        REG_ALARM_MINUTES: alarm_m = value;
        REG_ALARM_HOURS:   alarm_h = value;
        default: ;
      endcase
    endfunction

    // Step a 00-59 byte; bit 8 of the return is the carry out
    function logic [8:0] roll_sixty(logic [7:0] b);
      logic [4:0] units;
      logic [4:0] tens;
      logic       carry;
      units = {1'b0, b[3:0]} + 5'd1;
      tens  = {1'b0, b[7:4]};
      carry = 1'b0;
      if (units > 5'd9) begin
        units = 5'd0;
        tens  = tens + 5'd1;
        if (tens > 5'd5) begin
          tens  = 5'd0;
          carry = 1'b1;
        end
      end
      return {carry, tens[3:0], units[3:0]};
    endfunction

    // Step the hours byte; the tens digit is bits 6:4 and PM flips on the wrap
    function logic [7:0] roll_hours(logic [7:0] h);
      logic [4:0] units;
      logic [3:0] tens;
      logic       pm;
      units = {1'b0, h[3:0]} + 5'd1;
      tens  = {1'b0, h[6:4]};
      pm    = h[7];
      if ((tens == 4'd0 && units > 5'd9) || (tens != 4'd0 && units > 5'd1)) begin
        units = 5'd0;
        tens  = tens + 4'd1;
        if (tens > 4'd1) begin
          tens = 4'd0;
          pm   = !pm;
        end
      end
      return {pm, tens[2:0], units[3:0]};
    endfunction

    // Apply one input transfer to the time and queue the result it gives
    function void note_transfer(cmd_t cmd, logic [31:0] data);
      tod_result_t r;
      logic [8:0]  sec_step;
      logic [8:0]  min_step;
      r.hit = 1'b0;
      if (cmd == CMD_LOAD) begin
        {hours, minutes, seconds, tenths} = data;
      end else if (run_en) begin
        if (tenths >= 8'd9) begin
          tenths   = 8'd0;
          sec_step = roll_sixty(seconds);
          seconds  = sec_step[7:0];
          if (sec_step[8]) begin
            min_step = roll_sixty(minutes);
            minutes  = min_step[7:0];
            if (min_step[8]) hours = roll_hours(hours);
          end
        end else begin
          tenths = tenths + 8'd1;
        end
        r.hit = (tenths == alarm_t) && (seconds == alarm_s) &&
                (minutes == alarm_m) && (hours == alarm_h);
      end
      r.tenths  = tenths;
      r.seconds = seconds;
      r.minutes = minutes;
      r.hours   = hours;
      expected_times.push_back(r);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %h, got %h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_transfer(logic [31:0] data, logic hit);
      tod_result_t e;
      if (expected_times.size() == 0) begin
        $error("result transfer %h with nothing expected", data);
        mismatches++;
        return;
      end
      e = expected_times.pop_front();
      compare_field("tenths_now", e.tenths, data[7:0]);
      compare_field("seconds_now", e.seconds, data[15:8]);
      compare_field("minutes_now", e.minutes, data[23:16]);
      compare_field("hours_now", e.hours, data[31:24]);
      compare_field("alarm_hit", {7'd0, e.hit}, {7'd0, hit});
    endfunction

    function int pending();
      return expected_times.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [DATA_W-1:0]   s_tdata = '0;  // [7:0] tenths, [15:8] seconds,
                                      // [23:16] minutes, [31:24] hours
  logic                s_tuser = CMD_TICK;  // [0] cmd
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [DATA_W-1:0]   m_tdata;       // [7:0] tenths, [15:8] seconds,
                                      // [23:16] minutes, [31:24] hours
  logic                m_tuser;       // [0] alarm_hit
  logic                cfg_wen = 1'b0;
  logic [CFG_IDX-1:0]  cfg_idx = REG_RUN_ENABLE;
  logic [CFG_W-1:0]    cfg_wdata = '0;

  tod_scoreboard book;
  int            cycle_count = 0;
  bit            sender_gaps = 1'b0;
  bit            sink_stalls = 1'b0;
  bit            hold_off_req = 1'b0;
  logic [7:0]    al_s, al_m, al_h;

  bcd_time_of_day_clock u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_wen   (cfg_wen),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Watchdog: give up well beyond the slowest correct run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Sample both streams at the rising edge; check the result before noting
  // the new input, since a result always belongs to an earlier transfer
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) book.check_transfer(m_tdata, m_tuser);
      if (s_tvalid && s_tready) book.note_transfer(cmd_t'(s_tuser), s_tdata);
    end
  end

  // Mostly short idle stretches, now and then a long one
  function automatic int idle_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [7:0] rand_bcd60();
    int         v;
    logic [7:0] r;
    v      = $urandom_range(0, 59);
    r[7:4] = 4'(v / 10);
    r[3:0] = 4'(v % 10);
    return r;
  endfunction

  function automatic logic [7:0] rand_hours();
    int         v;
    logic [7:0] r;
    v      = $urandom_range(0, 11);
    r[7]   = 1'($urandom_range(0, 1));
    r[6:4] = 3'(v / 10);
    r[3:0] = 4'(v % 10);
    return r;
  endfunction

  // Result side: random stalls, plus one long hold-off on request so that
  // the block fills up and pushes back on the input
  initial begin : result_sink
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        m_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
        m_tready     = 1'b1;
      end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
        m_tready = 1'b0;
        repeat (idle_len() - 1) @(negedge clk);
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  // Offer one input transfer and hold it until it is taken. Valid stays high
  // between back-to-back items and drops only for a gap.
  task automatic send_item(input cmd_t cmd, input logic [31:0] data);
    int gap;
    gap = (sender_gaps && $urandom_range(0, 3) == 0) ? idle_len() : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = cmd;
    s_tdata  = data;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic tick();
    send_item(CMD_TICK, $urandom());
  endtask

  task automatic load_time(input logic [7:0] t, input logic [7:0] s,
                           input logic [7:0] m, input logic [7:0] h);
    send_item(CMD_LOAD, {h, m, s, t});
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_reg(input cfg_reg_t idx, input logic [7:0] value);
    @(negedge clk);
    cfg_wen   = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = value;
    @(posedge clk);
    book.store_reg(idx, value);
    @(negedge clk);
    cfg_wen = 1'b0;
  endtask

  task automatic set_alarm(input logic [7:0] t, input logic [7:0] s,
                           input logic [7:0] m, input logic [7:0] h);
    set_reg(REG_ALARM_TENTHS, t);
    set_reg(REG_ALARM_SECONDS, s);
    set_reg(REG_ALARM_MINUTES, m);
    set_reg(REG_ALARM_HOURS, h);
    al_s = s;
    al_m = m;
    al_h = h;
  endtask

  initial begin : stimulus
    int sel;
    book = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: alarm at midday, so the wrap from 11:59:59.9 AM hits it
    set_reg(REG_RUN_ENABLE, 8'd1);
    set_alarm(8'h00, 8'h00, 8'h00, 8'h80);
    load_time(8'h09, 8'h59, 8'h59, 8'h11);
    tick();
    // PM back to AM at midnight
    load_time(8'h09, 8'h59, 8'h59, 8'h91);
    tick();
    // hours 09 -> 10, and a units digit already past 9 with tens 0
    load_time(8'h09, 8'h59, 8'h59, 8'h09);
    tick();
    load_time(8'h09, 8'h59, 8'h59, 8'h0A);
    tick();
    // every byte at its top: all digits out of range, carries ripple through
    load_time(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    tick();
    load_time(8'h00, 8'h00, 8'h00, 8'h00);
    tick();
    tick();
    // tenths 8 -> 9 -> 0, seconds units digit out of range wraps into minutes
    load_time(8'h08, 8'h5A, 8'h00, 8'h00);
    tick();
    tick();
    // seconds tens digit out of range but not stepped: keep it
    load_time(8'h09, 8'hA5, 8'h3F, 8'h70);
    tick();
    // minutes units digit past 9
    load_time(8'h09, 8'h59, 8'h0F, 8'h75);
    tick();
    // hours tens digit out of range wraps and flips PM
    load_time(8'h09, 8'h59, 8'h59, 8'h71);
    tick();
    drain();

    // Clock stopped: ticks change nothing, loads still apply
    set_reg(REG_RUN_ENABLE, 8'd0);
    tick();
    load_time(8'h55, 8'hAA, 8'h55, 8'hAA);
    tick();

    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      // phases 1, 4 and 7 run without sender gaps so that the pipeline fills
      sender_gaps = (phase % 3 != 1);
      sink_stalls = (phase % 4 != 3);
      set_reg(REG_RUN_ENABLE, (phase == 2) ? 8'd0 : 8'd1);
      if (phase == 5)
        set_alarm(8'hFF, 8'hFF, 8'hFF, 8'hFF);
      else if (phase == 6)
        set_alarm(8'h00, 8'h00, 8'h00, 8'h00);
      else
        set_alarm(8'($urandom_range(1, 9)), rand_bcd60(), rand_bcd60(), rand_hours());

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 4 && n == 20) hold_off_req = 1'b1;
        sel = $urandom_range(0, 99);
        if (sel < 85) begin
          tick();
        end else if (sel < 91) begin
          // just short of the alarm, so a few ticks reach it
          load_time(8'($urandom_range(0, 9)), al_s, al_m, al_h);
        end else if (sel < 95) begin
          // close to a minute or hour wrap
          load_time(8'($urandom_range(0, 9)), 8'h59,
                    $urandom_range(0, 1) ? 8'h59 : rand_bcd60(), rand_hours());
        end else begin
          send_item(CMD_LOAD, $urandom());
        end
      end
    end

    drain();
    if (book.mismatches == 0 && book.pending() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
